// ----- rtl/atrlp_pkg.sv -----
// Shared constants, types and helper functions for the AT response line parser.
package atrlp_pkg;

    localparam int LINE_DEPTH  = 64;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);
    localparam int CNT_W       = $clog2(LINE_DEPTH + 1);
    localparam int MAX_RESULTS = 64;
    localparam int SPAN_W      = (CNT_W > $clog2(MAX_RESULTS)) ? CNT_W : $clog2(MAX_RESULTS);
    localparam int TAIL_LEN    = 12;
    localparam int TAIL_W      = TAIL_LEN * 8;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_CMD     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_UNSOL = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_FINAL = 2'd2;

    localparam logic [1:0] RC_NONE       = 2'd0;
    localparam logic [1:0] RC_OK         = 2'd1;
    localparam logic [1:0] RC_ERROR      = 2'd2;
    localparam logic [1:0] RC_NO_CARRIER = 2'd3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_T = 8'h54;

    // Suffix patterns, last received byte in the low bits.
    localparam logic [15:0] PAT_CRLF       = 16'h0D0A;
    localparam logic [31:0] PAT_OK         = 32'h4F4B_0D0A;
    localparam logic [55:0] PAT_ERROR      = 56'h45_5252_4F52_0D0A;
    localparam logic [95:0] PAT_NO_CARRIER = 96'h4E4F_2043_4152_5249_4552_0D0A;

    localparam int LEN_CRLF       = 2;
    localparam int LEN_OK         = 4;
    localparam int LEN_ERROR      = 7;
    localparam int LEN_NO_CARRIER = 12;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HI_RD,
        S_HI_CHK,
        S_LO_RD,
        S_LO_CHK,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_FINAL
    } t_state;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

// ----- rtl/at_response_line_parser.sv -----
// AT response line parser: line buffer memory, suffix matching and trimmed line emission.
//
// Input channel (i_in_valid / o_in_stall) takes one word per event: a received byte,
// a command-sent marker or a response timeout. Output channel (o_out_valid /
// i_out_stall) returns unsolicited line bytes, response text bytes and final result
// words, each run closed by o_last.
// A word that completes no line is taken without a stall and the block stays
// ready. A completed line is emitted from the line memory, which has separate write
// and read addresses: a backward scan and a forward scan find the trim points, each
// skipped blank being read and then tested; each emitted byte is read, then loaded
// into the output register, and a response closes with a final result word. Input
// is stalled while a line is being emitted. The output register holds a finished
// word while the receiver stalls; the emission walk waits on it, and an input
// word is accepted meanwhile once the walk is done.
// Synchronous reset returns to idle mode with an empty line, ready code OK, capture
// off and low power mode off. The line memory is not cleared; only bytes written
// since the last line clear are ever read.
module at_response_line_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_op,
    input  logic [7:0] i_rx_byte,
    input  logic       i_capture_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic       o_data_valid,
    output logic [1:0] o_result_code,
    output logic       o_last,
    output logic       o_overflow,
    output logic       o_release_dtr,
    output logic       o_activity_mark
);

    localparam int CNT_W  = atrlp_pkg::CNT_W;
    localparam int ADDR_W = atrlp_pkg::ADDR_W;
    localparam int TAIL_W = atrlp_pkg::TAIL_W;
    localparam int SPAN_W = atrlp_pkg::SPAN_W;

    // Line memory.
    logic [7:0] mem [atrlp_pkg::LINE_DEPTH];
    logic [7:0] r_rdata;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;

    // Control state.
    atrlp_pkg::t_state r_state, n_state;
    logic              r_mode, n_mode;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [TAIL_W-1:0] r_tail, n_tail;
    logic [1:0]        r_ready, n_ready;
    logic              r_capture, n_capture;
    logic              r_ovf, n_ovf;
    logic              r_low_power;
    logic              r_ev_resp, n_ev_resp;
    logic              r_ev_ovf, n_ev_ovf;
    logic [CNT_W-1:0]  r_hi, n_hi;
    logic [CNT_W-1:0]  r_lo, n_lo;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic              r_out_valid, n_out_valid;

    // First two stored bytes, for the command echo test.
    logic [7:0] r_b0, r_b1;

    // Output word.
    logic [1:0] r_kind, n_kind;
    logic [7:0] r_data_byte, n_data_byte;
    logic       r_data_valid, n_data_valid;
    logic [1:0] r_result_code, n_result_code;
    logic       r_last, n_last;
    logic       r_overflow, n_overflow;
    logic       r_release_dtr, n_release_dtr;
    logic       r_activity, n_activity;

    // Combinational helpers.
    logic              in_acc;
    logic              out_free;
    logic              full;
    logic [CNT_W-1:0]  fill_after;
    logic              ovf_after;
    logic [TAIL_W-1:0] push_tail;
    logic [7:0]        byte1;
    logic              m_crlf, m_ok, m_err, m_nc;
    logic [1:0]        code_new;
    logic [CNT_W-1:0]  cut;
    logic [CNT_W-1:0]  hi_m1;
    logic [CNT_W-1:0]  ptr_next;
    logic [CNT_W-1:0]  span;

    assign o_in_stall = (r_state != atrlp_pkg::S_IDLE);
    assign in_acc     = i_in_valid && (r_state == atrlp_pkg::S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign full       = (r_fill == CNT_W'(atrlp_pkg::LINE_DEPTH));
    assign fill_after = full ? r_fill : r_fill + CNT_W'(1);
    assign ovf_after  = r_ovf | full;
    assign push_tail  = {r_tail[TAIL_W-9:0], i_rx_byte};
    assign byte1      = (r_fill == CNT_W'(1)) ? i_rx_byte : r_b1;

    assign m_crlf = (fill_after >= CNT_W'(atrlp_pkg::LEN_CRLF))
                    && (push_tail[15:0] == atrlp_pkg::PAT_CRLF);
    assign m_ok   = (fill_after >= CNT_W'(atrlp_pkg::LEN_OK))
                    && (push_tail[31:0] == atrlp_pkg::PAT_OK);
    assign m_err  = (fill_after >= CNT_W'(atrlp_pkg::LEN_ERROR))
                    && (push_tail[55:0] == atrlp_pkg::PAT_ERROR);
    assign m_nc   = (fill_after >= CNT_W'(atrlp_pkg::LEN_NO_CARRIER))
                    && (push_tail[95:0] == atrlp_pkg::PAT_NO_CARRIER);

    always_comb begin
        if (m_ok) begin
            code_new = atrlp_pkg::RC_OK;
            cut      = CNT_W'(atrlp_pkg::LEN_OK);
        end else if (m_err) begin
            code_new = atrlp_pkg::RC_ERROR;
            cut      = CNT_W'(atrlp_pkg::LEN_ERROR);
        end else if (m_nc) begin
            code_new = atrlp_pkg::RC_NO_CARRIER;
            cut      = CNT_W'(atrlp_pkg::LEN_NO_CARRIER);
        end else begin
            // A stale ready code completes the response with no text cut.
            code_new = r_ready;
            cut      = '0;
        end
    end

    assign mem_we   = in_acc && (i_op == atrlp_pkg::OP_BYTE) && !full;
    assign hi_m1    = r_hi - CNT_W'(1);
    assign ptr_next = r_ptr + CNT_W'(1);
    assign span     = r_hi - r_lo;

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_fill        = r_fill;
        n_tail        = r_tail;
        n_ready       = r_ready;
        n_capture     = r_capture;
        n_ovf         = r_ovf;
        n_ev_resp     = r_ev_resp;
        n_ev_ovf      = r_ev_ovf;
        n_hi          = r_hi;
        n_lo          = r_lo;
        n_ptr         = r_ptr;
        n_out_valid   = r_out_valid && i_out_stall;
        n_kind        = r_kind;
        n_data_byte   = r_data_byte;
        n_data_valid  = r_data_valid;
        n_result_code = r_result_code;
        n_last        = r_last;
        n_overflow    = r_overflow;
        n_release_dtr = r_release_dtr;
        n_activity    = r_activity;
        rd_addr       = r_ptr[ADDR_W-1:0];

        unique case (r_state)
            atrlp_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (i_op)
                        atrlp_pkg::OP_CMD: begin
                            n_mode    = 1'b0;
                            n_ready   = atrlp_pkg::RC_NONE;
                            n_capture = i_capture_data;
                        end
                        atrlp_pkg::OP_TIMEOUT: begin
                            n_fill    = '0;
                            n_tail    = '0;
                            n_ovf     = 1'b0;
                            n_capture = 1'b0;
                        end
                        atrlp_pkg::OP_BYTE: begin
                            n_tail = push_tail;
                            n_fill = fill_after;
                            n_ovf  = ovf_after;
                            if (!r_mode) begin
                                if (m_crlf) begin
                                    n_fill = '0;
                                    n_tail = '0;
                                    n_ovf  = 1'b0;
                                    if ((r_b0 == atrlp_pkg::CH_UPPER_A)
                                            && (byte1 == atrlp_pkg::CH_UPPER_T)) begin
                                        n_mode = 1'b1;
                                    end else begin
                                        n_ev_resp = 1'b0;
                                        n_ev_ovf  = ovf_after;
                                        n_hi      = fill_after;
                                        n_state   = atrlp_pkg::S_HI_RD;
                                    end
                                end
                            end else if ((i_rx_byte == atrlp_pkg::CH_LF)
                                    && (code_new != atrlp_pkg::RC_NONE)) begin
                                n_ready   = code_new;
                                n_ev_resp = 1'b1;
                                n_ev_ovf  = ovf_after;
                                n_hi      = ovf_after ? fill_after : fill_after - cut;
                                n_state   = r_capture ? atrlp_pkg::S_HI_RD
                                                      : atrlp_pkg::S_FINAL;
                                n_capture = 1'b0;
                                n_mode    = 1'b0;
                                n_fill    = '0;
                                n_tail    = '0;
                                n_ovf     = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            atrlp_pkg::S_HI_RD: begin
                rd_addr = hi_m1[ADDR_W-1:0];
                if (r_hi == '0) begin
                    n_state = r_ev_resp ? atrlp_pkg::S_FINAL : atrlp_pkg::S_IDLE;
                end else begin
                    n_state = atrlp_pkg::S_HI_CHK;
                end
            end
            atrlp_pkg::S_HI_CHK: begin
                rd_addr = hi_m1[ADDR_W-1:0];
                if (atrlp_pkg::is_space(r_rdata)) begin
                    n_hi    = hi_m1;
                    n_state = atrlp_pkg::S_HI_RD;
                end else begin
                    n_lo    = '0;
                    n_state = atrlp_pkg::S_LO_RD;
                end
            end
            atrlp_pkg::S_LO_RD: begin
                rd_addr = r_lo[ADDR_W-1:0];
                n_state = atrlp_pkg::S_LO_CHK;
            end
            atrlp_pkg::S_LO_CHK: begin
                rd_addr = r_lo[ADDR_W-1:0];
                // The backward scan left a non-blank at r_hi - 1, so this stops there.
                if (atrlp_pkg::is_space(r_rdata)) begin
                    n_lo    = r_lo + CNT_W'(1);
                    n_state = atrlp_pkg::S_LO_RD;
                end else begin
                    if (r_ev_resp && (SPAN_W'(span) > SPAN_W'(atrlp_pkg::MAX_RESULTS - 1))) begin
                        n_hi = r_lo + CNT_W'(atrlp_pkg::MAX_RESULTS - 1);
                    end
                    n_ptr   = r_lo;
                    n_state = atrlp_pkg::S_EMIT_RD;
                end
            end
            atrlp_pkg::S_EMIT_RD: begin
                n_state = atrlp_pkg::S_EMIT_OUT;
            end
            atrlp_pkg::S_EMIT_OUT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_kind        = r_ev_resp ? atrlp_pkg::KIND_DATA : atrlp_pkg::KIND_UNSOL;
                    n_data_byte   = r_rdata;
                    n_data_valid  = 1'b1;
                    n_result_code = atrlp_pkg::RC_NONE;
                    n_last        = !r_ev_resp && (ptr_next == r_hi);
                    n_overflow    = r_ev_ovf;
                    n_release_dtr = 1'b0;
                    n_activity    = !r_ev_resp && (ptr_next == r_hi);
                    n_ptr         = ptr_next;
                    if (ptr_next == r_hi) begin
                        n_state = r_ev_resp ? atrlp_pkg::S_FINAL : atrlp_pkg::S_IDLE;
                    end else begin
                        n_state = atrlp_pkg::S_EMIT_RD;
                    end
                end
            end
            atrlp_pkg::S_FINAL: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_kind        = atrlp_pkg::KIND_FINAL;
                    n_data_byte   = '0;
                    n_data_valid  = 1'b0;
                    n_result_code = r_ready;
                    n_last        = 1'b1;
                    n_overflow    = r_ev_ovf;
                    n_release_dtr = r_low_power;
                    n_activity    = 1'b1;
                    n_state       = atrlp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = atrlp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_fill[ADDR_W-1:0]] <= i_rx_byte;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atrlp_pkg::S_IDLE;
            r_mode      <= 1'b0;
            r_fill      <= '0;
            r_tail      <= '0;
            r_ready     <= atrlp_pkg::RC_OK;
            r_capture   <= 1'b0;
            r_ovf       <= 1'b0;
            r_low_power <= 1'b0;
            r_ev_resp   <= 1'b0;
            r_ev_ovf    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_fill      <= n_fill;
            r_tail      <= n_tail;
            r_ready     <= n_ready;
            r_capture   <= n_capture;
            r_ovf       <= n_ovf;
            r_ev_resp   <= n_ev_resp;
            r_ev_ovf    <= n_ev_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_low_power <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi          <= n_hi;
        r_lo          <= n_lo;
        r_ptr         <= n_ptr;
        r_kind        <= n_kind;
        r_data_byte   <= n_data_byte;
        r_data_valid  <= n_data_valid;
        r_result_code <= n_result_code;
        r_last        <= n_last;
        r_overflow    <= n_overflow;
        r_release_dtr <= n_release_dtr;
        r_activity    <= n_activity;
        if (mem_we && (r_fill == CNT_W'(0))) begin
            r_b0 <= i_rx_byte;
        end
        if (mem_we && (r_fill == CNT_W'(1))) begin
            r_b1 <= i_rx_byte;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_data_byte     = r_data_byte;
    assign o_data_valid    = r_data_valid;
    assign o_result_code   = r_result_code;
    assign o_last          = r_last;
    assign o_overflow      = r_overflow;
    assign o_release_dtr   = r_release_dtr;
    assign o_activity_mark = r_activity;

endmodule
